// File: hdl/fsc_pkg.sv
// Shared types and constants for the FASTA syntax checker.
package fsc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int LINE_BITS_DEF  = 32;
  localparam int OUT_DEPTH      = 4;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_COMMENT,
    PH_SEQUENCE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    HP_NONE,
    HP_TITLE,
    HP_GAP,
    HP_DESC
  } hpart_t;

  typedef enum logic [2:0] {
    KIND_HEADER,
    KIND_COMMENT,
    KIND_SEQUENCE,
    KIND_ERROR,
    KIND_SUMMARY
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_DATA_MISSING,
    ERR_BAD_CHARS,
    ERR_EXPECTED_HEADER,
    ERR_NO_TITLE,
    ERR_NO_SEQUENCES
  } err_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_HEADER,
    OUT_COMMENT,
    OUT_SEQUENCE,
    OUT_FAIL
  } outcome_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_stream;
  } src_t;

  typedef struct packed {
    logic [2:0]  line_kind;
    logic [31:0] line_number;
    logic [15:0] residue_count;
    logic [15:0] gap_count;
    logic [15:0] title_length;
    logic        has_description;
    logic [2:0]  error_code;
    logic [15:0] record_count;
    logic        is_last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// File: hdl/fsc_core.sv
// Line parser: phase machine, per-line counters and result formation.
module fsc_core
  import fsc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  src_t  item,
  output push_t push
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;

  phase_t                phase, phase_next;
  logic [LINE_BITS-1:0]  line_counter, line_counter_next;
  logic                  line_has_content, line_has_content_next;
  logic [7:0]            first_char, first_char_next;
  logic [1:0]            pending_space, pending_space_next;
  logic                  line_bad, line_bad_next;
  logic [COUNT_BITS-1:0] letters_on_line, letters_on_line_next;
  logic [COUNT_BITS-1:0] dashes_on_line, dashes_on_line_next;
  logic [COUNT_BITS-1:0] title_chars, title_chars_next;
  hpart_t                header_part, header_part_next;
  logic                  record_has_data, record_has_data_next;
  logic [COUNT_BITS-1:0] records_seen, records_seen_next;
  logic [2:0]            stored_error, stored_error_next;
  logic                  line_open, line_open_next;

  logic [7:0]            c;
  logic                  eos;
  logic                  live;
  logic                  newline;
  logic [LINE_BITS-1:0]  line_num;
  logic                  ending;
  outcome_t              outcome;
  logic [2:0]            fail_code;
  logic [COUNT_BITS-1:0] records_inc;
  logic [COUNT_BITS-1:0] records_post;
  logic                  rhd_post;
  logic [2:0]            err_post;
  logic                  has_line;
  result_t               line_res;
  result_t               sum_res;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CHAR_SPACE) || (ch >= 8'd9 && ch <= 8'd13);
  endfunction

  function automatic logic is_residue(input logic [7:0] ch);
    logic [7:0] low;
    logic       letter;
    low    = ch | 8'h20;
    letter = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    return letter && (low != 8'h6A) && (low != 8'h6F);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  assign c       = item.text_byte;
  assign eos     = item.end_of_stream;
  assign live    = fire && !eos && (phase != PH_DONE);
  assign newline = (c == CHAR_NL);
  assign ending  = fire && (eos ? line_open : (live && newline));

  always_comb begin
    line_num = line_counter;
    if (live && !line_open && line_counter != LINE_MAX) begin
      line_num = line_counter + 1'b1;
    end
  end

  always_comb begin
    outcome   = OUT_NONE;
    fail_code = ERR_NONE;
    if (!line_has_content) begin
      outcome = OUT_NONE;
    end else if (first_char == CHAR_GT) begin
      if (phase != PH_HEADER && !record_has_data) begin
        outcome   = OUT_FAIL;
        fail_code = ERR_DATA_MISSING;
      end else if (header_part == HP_NONE) begin
        outcome   = OUT_FAIL;
        fail_code = ERR_NO_TITLE;
      end else begin
        outcome = OUT_HEADER;
      end
    end else if (phase == PH_HEADER) begin
      outcome   = OUT_FAIL;
      fail_code = ERR_EXPECTED_HEADER;
    end else if (phase == PH_COMMENT && first_char == CHAR_SEMI) begin
      outcome = OUT_COMMENT;
    end else if (line_bad) begin
      outcome   = OUT_FAIL;
      fail_code = ERR_BAD_CHARS;
    end else begin
      outcome = OUT_SEQUENCE;
    end
  end

  assign records_inc  = sat_inc(records_seen);
  assign records_post = (ending && outcome == OUT_HEADER) ? records_inc : records_seen;
  assign err_post     = (ending && outcome == OUT_FAIL) ? fail_code : stored_error;
  assign has_line     = ending && (outcome != OUT_NONE);

  always_comb begin
    rhd_post = record_has_data;
    if (ending && outcome == OUT_HEADER) begin
      rhd_post = 1'b0;
    end else if (ending && outcome == OUT_SEQUENCE) begin
      rhd_post = 1'b1;
    end
  end

  // next state
  always_comb begin
    logic                  ws;
    logic                  seq_char;
    logic [COUNT_BITS:0]   wide;
    logic [COUNT_BITS-1:0] t1;
    phase_next            = phase;
    line_counter_next     = line_counter;
    line_has_content_next = line_has_content;
    first_char_next       = first_char;
    pending_space_next    = pending_space;
    line_bad_next         = line_bad;
    letters_on_line_next  = letters_on_line;
    dashes_on_line_next   = dashes_on_line;
    title_chars_next      = title_chars;
    header_part_next      = header_part;
    record_has_data_next  = record_has_data;
    records_seen_next     = records_seen;
    stored_error_next     = stored_error;
    line_open_next        = line_open;
    ws       = is_ws(c);
    seq_char = 1'b0;
    wide     = {1'b0, title_chars} + {1'b0, letters_on_line};
    t1       = wide[COUNT_BITS] ? COUNT_MAX : wide[COUNT_BITS-1:0];
    if (fire && eos) begin
      phase_next            = PH_HEADER;
      line_counter_next     = '0;
      line_has_content_next = 1'b0;
      first_char_next       = '0;
      pending_space_next    = '0;
      line_bad_next         = 1'b0;
      letters_on_line_next  = '0;
      dashes_on_line_next   = '0;
      title_chars_next      = '0;
      header_part_next      = HP_NONE;
      record_has_data_next  = 1'b0;
      records_seen_next     = '0;
      stored_error_next     = ERR_NONE;
      line_open_next        = 1'b0;
    end else if (live) begin
      line_counter_next = line_num;
      line_open_next    = !newline;
      if (newline) begin
        line_has_content_next = 1'b0;
        first_char_next       = '0;
        pending_space_next    = '0;
        line_bad_next         = 1'b0;
        letters_on_line_next  = '0;
        dashes_on_line_next   = '0;
        title_chars_next      = '0;
        header_part_next      = HP_NONE;
        records_seen_next     = records_post;
        record_has_data_next  = rhd_post;
        stored_error_next     = err_post;
        case (outcome)
          OUT_HEADER:   phase_next = PH_COMMENT;
          OUT_SEQUENCE: phase_next = PH_SEQUENCE;
          OUT_FAIL:     phase_next = PH_DONE;
          default:      phase_next = phase;
        endcase
      end else begin
        if (!line_has_content) begin
          if (!ws) begin
            line_has_content_next = 1'b1;
            first_char_next       = c;
            seq_char              = (c != CHAR_GT);
          end
        end else if (first_char == CHAR_GT) begin
          unique case (header_part)
            HP_NONE: begin
              if (!ws) begin
                header_part_next = HP_TITLE;
                title_chars_next = {{(COUNT_BITS-1){1'b0}}, 1'b1};
              end
            end
            HP_TITLE: begin
              if (c == CHAR_SPACE || c == CHAR_TAB) begin
                header_part_next = HP_GAP;
              end else if (ws) begin
                letters_on_line_next = sat_inc(letters_on_line);
              end else begin
                title_chars_next     = sat_inc(t1);
                letters_on_line_next = '0;
              end
            end
            HP_GAP: begin
              if (!ws) begin
                header_part_next = HP_DESC;
              end
            end
            HP_DESC: begin
              header_part_next = HP_DESC;
            end
          endcase
        end else if (ws) begin
          pending_space_next = pending_space | ((c == CHAR_SPACE) ? 2'b01 : 2'b10);
        end else begin
          seq_char = 1'b1;
        end
        if (seq_char) begin
          if (pending_space[1]) begin
            line_bad_next = 1'b1;
          end
          pending_space_next = '0;
          if (is_residue(c)) begin
            letters_on_line_next = sat_inc(letters_on_line);
          end else if (c == CHAR_DASH) begin
            dashes_on_line_next = sat_inc(dashes_on_line);
          end else begin
            line_bad_next = 1'b1;
          end
        end
      end
    end
  end

  // outputs
  always_comb begin
    line_res              = '0;
    line_res.line_number  = 32'(line_num);
    line_res.record_count = 16'(records_post);
    line_res.is_last      = !eos;
    case (outcome)
      OUT_HEADER: begin
        line_res.line_kind       = KIND_HEADER;
        line_res.title_length    = 16'(title_chars);
        line_res.has_description = (header_part == HP_DESC);
      end
      OUT_COMMENT: begin
        line_res.line_kind = KIND_COMMENT;
      end
      OUT_SEQUENCE: begin
        line_res.line_kind     = KIND_SEQUENCE;
        line_res.residue_count = 16'(letters_on_line);
        line_res.gap_count     = 16'(dashes_on_line);
      end
      default: begin
        line_res.line_kind  = KIND_ERROR;
        line_res.error_code = fail_code;
      end
    endcase

    sum_res              = '0;
    sum_res.line_number  = 32'(line_num);
    sum_res.record_count = 16'(records_post);
    sum_res.is_last      = 1'b1;
    if (err_post != ERR_NONE) begin
      sum_res.line_kind  = KIND_SUMMARY;
      sum_res.error_code = err_post;
    end else if (records_post == '0) begin
      sum_res.line_kind  = KIND_ERROR;
      sum_res.error_code = ERR_NO_SEQUENCES;
    end else if (!rhd_post) begin
      sum_res.line_kind  = KIND_ERROR;
      sum_res.error_code = ERR_DATA_MISSING;
    end else begin
      sum_res.line_kind  = KIND_SUMMARY;
      sum_res.error_code = ERR_NONE;
    end

    push.second = sum_res;
    if (fire && eos) begin
      push.count = has_line ? 2'd2 : 2'd1;
      push.first = has_line ? line_res : sum_res;
    end else begin
      push.count = has_line ? 2'd1 : 2'd0;
      push.first = line_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      line_counter     <= '0;
      line_has_content <= 1'b0;
      first_char       <= '0;
      pending_space    <= '0;
      line_bad         <= 1'b0;
      letters_on_line  <= '0;
      dashes_on_line   <= '0;
      title_chars      <= '0;
      header_part      <= HP_NONE;
      record_has_data  <= 1'b0;
      records_seen     <= '0;
      stored_error     <= ERR_NONE;
      line_open        <= 1'b0;
    end else begin
      phase            <= phase_next;
      line_counter     <= line_counter_next;
      line_has_content <= line_has_content_next;
      first_char       <= first_char_next;
      pending_space    <= pending_space_next;
      line_bad         <= line_bad_next;
      letters_on_line  <= letters_on_line_next;
      dashes_on_line   <= dashes_on_line_next;
      title_chars      <= title_chars_next;
      header_part      <= header_part_next;
      record_has_data  <= record_has_data_next;
      records_seen     <= records_seen_next;
      stored_error     <= stored_error_next;
      line_open        <= line_open_next;
    end
  end

endmodule

// File: hdl/fsc_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one.
module fsc_out_fifo
  import fsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data
);

  localparam int PTR_BITS = $clog2(OUT_DEPTH);

  result_t             mem [OUT_DEPTH];
  logic [PTR_BITS-1:0] head, head_next;
  logic [PTR_BITS-1:0] tail, tail_next;
  logic [PTR_BITS-1:0] tail_plus;
  logic [PTR_BITS:0]   count, count_next;
  logic                pop;

  assign pop       = res_valid && res_ready;
  assign res_valid = (count != '0);
  assign res_data  = mem[head];
  assign room      = (count <= (PTR_BITS+1)'(OUT_DEPTH - 2));
  assign tail_plus = tail + 1'b1;

  always_comb begin
    head_next  = pop ? head + 1'b1 : head;
    tail_next  = tail + PTR_BITS'(push.count);
    count_next = count + (PTR_BITS+1)'(push.count) - (PTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[tail_plus] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

// File: hdl/fasta_syntax_checker_top.sv
// Top level of the FASTA syntax checker: request register, parser and result queue.
//
// Usage:
//   Requests enter on src_valid/src_ready/src_data, one text byte or an
//   end-of-stream mark each. Results leave on res_valid/res_ready/res_data.
//   A byte ending a nonblank line (newline) gives one result; other bytes give
//   none. An end-of-stream request gives a summary, preceded by the verdict on
//   an unterminated last line if any; is_last marks each request's last result.
// Timing:
//   One request per cycle while the queue has room. A request waits in the input
//   register until the parser takes it; all of its results are then written into
//   the queue together, in the cycle it is parsed. The four-entry result queue
//   sets the limit: the parser takes a request only when two entries are free,
//   so a stalled receiver backs the queue up and then drops src_ready once
//   more than two results wait and a request is held in the input register.
// Reset:
//   rst (synchronous) empties the queue and the input register and returns the
//   parser to expect-header with all counters at zero. After an end-of-stream
//   request the parser returns to the same state on its own.
module fasta_syntax_checker_top
  import fsc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    src_valid,
  output logic    src_ready,
  input  src_t    src_data,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data
);

  logic  stage_valid;
  src_t  stage_data;
  logic  fire;
  logic  room;
  push_t push;

  assign fire      = stage_valid && room;
  assign src_ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src_ready) begin
      stage_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      stage_data <= src_data;
    end
  end

  fsc_core #(
    .COUNT_BITS(COUNT_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .item(stage_data),
    .push(push)
  );

  fsc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

`ifndef SYNTH
  a_push_needs_fire: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> fire)
    else $error("results pushed without a parsed request");

  a_byte_single: assert property (@(posedge clk) disable iff (rst)
    (fire && !stage_data.end_of_stream) |-> (push.count != 2'd2))
    else $error("text byte produced two results");

  a_eos_last: assert property (@(posedge clk) disable iff (rst)
    (fire && stage_data.end_of_stream) |->
      ((push.count == 2'd1 && push.first.is_last) ||
       (push.count == 2'd2 && push.second.is_last && !push.first.is_last)))
    else $error("end of stream without a final result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule

// File: tb/sv/fsc_checker.sv
// Checker for the FASTA syntax checker: predicts each line verdict and summary from the requests and compares.
`timescale 1ns / 100ps
module fsc_checker
  import fsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    src_valid,
  input  logic    src_ready,
  input  src_t    src_data,
  input  logic    res_valid,
  input  logic    res_ready,
  input  result_t res_data,
  output int      mismatches,
  output int      pending,
  output int      live_requests
);

  phase_t      ph;
  hpart_t      hpart;
  err_t        saved_err;
  logic [31:0] line_no;
  logic        open_line;
  logic        has_text;
  logic        bad_line;
  logic        rec_data;
  logic [7:0]  lead_char;
  logic [1:0]  ws_seen;
  logic [15:0] letters;
  logic [15:0] dashes;
  logic [15:0] title_len;
  logic [15:0] records;
  result_t     line_verdicts[$];
  result_t     step_out[$];
  int          result_no;

  function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= 8'h0D);
  endfunction

  function automatic bit is_residue(logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    if (c < "A" || l < "a" || l > "z") return 1'b0;
    if (c > "Z" && c < "a") return 1'b0;
    return l != "j" && l != "o";
  endfunction

  function automatic void clear_line();
    has_text  = 1'b0;
    lead_char = 8'h00;
    ws_seen   = 2'b00;
    bad_line  = 1'b0;
    letters   = 16'd0;
    dashes    = 16'd0;
    title_len = 16'd0;
    hpart     = HP_NONE;
  endfunction

  function automatic void reset_parser();
    ph        = PH_HEADER;
    line_no   = 32'd0;
    clear_line();
    rec_data  = 1'b0;
    records   = 16'd0;
    saved_err = ERR_NONE;
    open_line = 1'b0;
  endfunction

  function automatic void emit(kind_t k, logic [15:0] res, logic [15:0] gap,
                               logic [15:0] title, bit desc, err_t e);
    result_t r;
    r.line_kind       = k;
    r.line_number     = line_no;
    r.residue_count   = res;
    r.gap_count       = gap;
    r.title_length    = title;
    r.has_description = desc;
    r.error_code      = e;
    r.record_count    = records;
    r.is_last         = 1'b0;
    step_out = {step_out, r};
  endfunction

  function automatic void fail(err_t e);
    saved_err = e;
    ph        = PH_DONE;
    emit(KIND_ERROR, 16'd0, 16'd0, 16'd0, 1'b0, e);
  endfunction

  function automatic void take_byte(logic [7:0] c);
    bit w;
    w = is_blank(c);
    if (!has_text) begin
      if (w) return;
      has_text  = 1'b1;
      lead_char = c;
      if (c == CHAR_GT) return;
    end else if (lead_char == CHAR_GT) begin
      case (hpart)
        HP_NONE: begin
          if (!w) begin
            hpart     = HP_TITLE;
            title_len = 16'd1;
          end
        end
        HP_TITLE: begin
          if (c == CHAR_SPACE || c == CHAR_TAB) begin
            hpart = HP_GAP;
          end else if (w) begin
            letters = sat_add16(letters, 16'd1);
          end else begin
            title_len = sat_add16(sat_add16(title_len, letters), 16'd1);
            letters   = 16'd0;
          end
        end
        HP_GAP: begin
          if (!w) hpart = HP_DESC;
        end
        default: ;
      endcase
      return;
    end else if (w) begin
      ws_seen |= (c == CHAR_SPACE) ? 2'b01 : 2'b10;
      return;
    end
    if (ws_seen[1]) bad_line = 1'b1;
    ws_seen = 2'b00;
    if (is_residue(c)) letters = sat_add16(letters, 16'd1);
    else if (c == CHAR_DASH) dashes = sat_add16(dashes, 16'd1);
    else bad_line = 1'b1;
  endfunction

  function automatic void close_line();
    open_line = 1'b0;
    if (!has_text || ph == PH_DONE) begin
      clear_line();
      return;
    end
    if (lead_char == CHAR_GT) begin
      if (ph != PH_HEADER && !rec_data) begin
        fail(ERR_DATA_MISSING);
      end else if (hpart == HP_NONE) begin
        fail(ERR_NO_TITLE);
      end else begin
        records  = sat_add16(records, 16'd1);
        rec_data = 1'b0;
        ph       = PH_COMMENT;
        emit(KIND_HEADER, 16'd0, 16'd0, title_len, hpart == HP_DESC, ERR_NONE);
      end
    end else if (ph == PH_HEADER) begin
      fail(ERR_EXPECTED_HEADER);
    end else if (ph == PH_COMMENT && lead_char == CHAR_SEMI) begin
      emit(KIND_COMMENT, 16'd0, 16'd0, 16'd0, 1'b0, ERR_NONE);
    end else if (bad_line) begin
      fail(ERR_BAD_CHARS);
    end else begin
      ph       = PH_SEQUENCE;
      rec_data = 1'b1;
      emit(KIND_SEQUENCE, letters, dashes, 16'd0, 1'b0, ERR_NONE);
    end
    clear_line();
  endfunction

  // Returns whether the request was acted on rather than dropped.
  function automatic bit parse_request(src_t r);
    bit      live;
    int      n;
    result_t x;
    live = r.end_of_stream || ph != PH_DONE;
    step_out.delete();
    if (r.end_of_stream) begin
      if (open_line) close_line();
      if (saved_err != ERR_NONE)
        emit(KIND_SUMMARY, 16'd0, 16'd0, 16'd0, 1'b0, saved_err);
      else if (records == 16'd0)
        emit(KIND_ERROR, 16'd0, 16'd0, 16'd0, 1'b0, ERR_NO_SEQUENCES);
      else if (!rec_data)
        emit(KIND_ERROR, 16'd0, 16'd0, 16'd0, 1'b0, ERR_DATA_MISSING);
      else
        emit(KIND_SUMMARY, 16'd0, 16'd0, 16'd0, 1'b0, ERR_NONE);
      reset_parser();
    end else if (live) begin
      if (!open_line) begin
        open_line = 1'b1;
        if (line_no != 32'hFFFF_FFFF) line_no = line_no + 32'd1;
      end
      if (r.text_byte == CHAR_NL) close_line();
      else take_byte(r.text_byte);
    end
    n = step_out.size();
    for (int i = 0; i < n; i++) begin
      x = step_out[i];
      x.is_last = (i == n - 1);
      line_verdicts = {line_verdicts, x};
    end
    return live;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t: result %0d %s: got %0d, expected %0d", $time, result_no, what, got, want);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    result_no++;
    if (line_verdicts.size() == 0) begin
      report("arrived with none expected, line_number", got.line_number, 64'd0);
      return;
    end
    want = line_verdicts.pop_front();
    if (got.line_kind !== want.line_kind)
      report("line_kind", got.line_kind, want.line_kind);
    if (got.line_number !== want.line_number)
      report("line_number", got.line_number, want.line_number);
    if (got.residue_count !== want.residue_count)
      report("residue_count", got.residue_count, want.residue_count);
    if (got.gap_count !== want.gap_count)
      report("gap_count", got.gap_count, want.gap_count);
    if (got.title_length !== want.title_length)
      report("title_length", got.title_length, want.title_length);
    if (got.has_description !== want.has_description)
      report("has_description", got.has_description, want.has_description);
    if (got.error_code !== want.error_code)
      report("error_code", got.error_code, want.error_code);
    if (got.record_count !== want.record_count)
      report("record_count", got.record_count, want.record_count);
    if (got.is_last !== want.is_last)
      report("is_last", got.is_last, want.is_last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_parser();
      line_verdicts.delete();
      pending       <= 0;
      live_requests <= 0;
    end else begin
      if (res_valid && res_ready) check_result(res_data);
      if (src_valid && src_ready) begin
        if (parse_request(src_data)) live_requests <= live_requests + 1;
      end
      pending <= line_verdicts.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top: feeds FASTA text to the syntax checker, stalls the result side, gives the verdict.
`timescale 1ns / 100ps
module tb_top;
  import fsc_pkg::*;

  localparam int ITEM_TARGET = 900;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    src_valid = 1'b0;
  logic    src_ready;
  src_t    src_data  = '0;
  logic    res_valid;
  logic    res_ready = 1'b0;
  result_t res_data;

  int      mismatches;
  int      pending;
  int      live;
  int      cycles    = 0;
  int      rx_hold   = 0;
  int      rx_stall;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;

  fasta_syntax_checker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  fsc_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .src_valid     (src_valid),
    .src_ready     (src_ready),
    .src_data      (src_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_data      (res_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .live_requests (live)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold ready low for a random stretch after each result.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (res_valid && res_ready) begin
      if ($urandom_range(0, 30) == 0) rx_steady = !rx_steady;
      rx_stall = rx_steady ? 0 : $urandom_range(0, 14);
      rx_hold   <= rx_stall;
      res_ready <= (rx_stall == 0);
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      res_ready <= (rx_hold == 1);
    end else begin
      res_ready <= 1'b1;
    end
  end

  task automatic send_req(logic [7:0] b, logic eos);
    int   gap;
    src_t r;
    if ($urandom_range(0, 40) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.text_byte     = b;
    r.end_of_stream = eos;
    src_valid <= 1'b1;
    src_data  <= r;
    do @(posedge clk); while (!src_ready);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_req(b, 1'b0);
  endtask

  task automatic send_eos();
    send_req(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] residue_byte();
    logic [7:0] c;
    do c = $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                : 8'($urandom_range(8'h61, 8'h7A));
    while ((c | 8'h20) == "j" || (c | 8'h20) == "o");
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return CHAR_TAB;
      1: return 8'h0B;
      2: return 8'h0C;
      3: return 8'h0D;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] title_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(8'h0B, 8'h0D));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] split_byte();
    return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  task automatic send_pad();
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) send_byte(blank_byte());
  endtask

  task automatic send_header(bit no_title);
    send_pad();
    send_byte(CHAR_GT);
    if ($urandom_range(0, 3) == 0) send_byte(split_byte());
    if (!no_title) begin
      repeat ($urandom_range(1, 8)) send_byte(title_byte());
      if ($urandom_range(0, 1)) begin
        send_byte(split_byte());
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
    send_pad();
    send_byte(CHAR_NL);
  endtask

  task automatic send_comment();
    send_pad();
    send_byte(CHAR_SEMI);
    repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    send_byte(CHAR_NL);
  endtask

  task automatic send_seq(bit bad_char, bit inner_tab, bit closed);
    int n;
    int cut;
    n   = $urandom_range(1, 20);
    cut = $urandom_range(0, n - 1);
    send_pad();
    for (int i = 0; i < n; i++) begin
      if (i == cut && inner_tab) send_byte(blank_byte());
      if (i == cut && bad_char) send_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
        0, 1: send_byte(CHAR_DASH);
        2: send_byte(CHAR_SPACE);
        default: send_byte(residue_byte());
      endcase
    end
    send_pad();
    if (closed) send_byte(CHAR_NL);
  endtask

  task automatic send_noise_line();
    repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
    send_byte(CHAR_NL);
  endtask

  task automatic gen_stream();
    int recs;
    int flaw;
    int at;
    int nseq;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send_noise_line();
      send_eos();
      return;
    end
    recs = $urandom_range(1, 3);
    flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    at   = $urandom_range(0, recs - 1);
    if (flaw == 4) send_seq(1'b0, 1'b0, 1'b1);
    for (int r = 0; r < recs; r++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pad();
        send_byte(CHAR_NL);
      end
      send_header(flaw == 1 && r == at);
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) send_comment();
      nseq = (flaw == 2 && r == at) ? 0 : $urandom_range(1, 3);
      for (int s = 0; s < nseq; s++)
        send_seq(flaw == 3 && r == at && s == 0, flaw == 6 && r == at && s == 0, 1'b1);
      if (flaw == 5 && r == at) send_comment();
    end
    if ($urandom_range(0, 3) == 0) send_seq(1'b0, 1'b0, 1'b0);
    send_eos();
  endtask

  task automatic run_directed();
    send_eos();
    send_text(" >ab\013c d\n;\n\n aZ-\t\n");
    send_eos();
    send_text("Q\nx");
    send_eos();
    send_text(">\t \n");
    send_eos();
    send_text(">t\n>u\n");
    send_eos();
    send_text(">t\nA\tC");
    send_eos();
    send_text(">t\nA\n;x");
    send_eos();
    send_text(">t\nJ\n");
    send_eos();
    send_text(">t\n");
    send_eos();
  endtask

  initial begin
    int base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    base = live;
    while (live - base < ITEM_TARGET) gen_stream();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
